// ===== sv/bsl_pkg.sv =====
package bsl_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int LINE_BITS_DEF   = 24;
  localparam int COLUMN_BITS_DEF = 16;

  localparam int NKW    = 17;
  localparam int KW_LEN_MAX = 12;

  typedef enum logic [10:0] {
    M_IDLE       = 11'b000_0000_0001,
    M_COMMENT    = 11'b000_0000_0010,
    M_SLASH      = 11'b000_0000_0100,
    M_WORD       = 11'b000_0000_1000,
    M_INT        = 11'b000_0001_0000,
    M_INT_DOT    = 11'b000_0010_0000,
    M_FRAC       = 11'b000_0100_0000,
    M_FRAC_DOT   = 11'b000_1000_0000,
    M_TAIL       = 11'b001_0000_0000,
    M_DOT        = 11'b010_0000_0000,
    M_DOT_DIGITS = 11'b100_0000_0000
  } mode_t;

  localparam logic [4:0] K_EOF     = 5'd0;
  localparam logic [4:0] K_IDENT   = 5'd1;
  localparam logic [4:0] K_NUMBER  = 5'd2;
  localparam logic [4:0] K_LBRACE  = 5'd14;
  localparam logic [4:0] K_RBRACE  = 5'd15;
  localparam logic [4:0] K_EQUAL   = 5'd16;
  localparam logic [4:0] K_RANGE   = 5'd17;
  localparam logic [4:0] K_DOT     = 5'd18;
  localparam logic [4:0] K_PLUS    = 5'd19;
  localparam logic [4:0] K_MINUS   = 5'd20;
  localparam logic [4:0] K_LPAREN  = 5'd21;
  localparam logic [4:0] K_RPAREN  = 5'd22;
  localparam logic [4:0] K_COMMA   = 5'd23;
  localparam logic [4:0] K_INVALID = 5'd30;

  localparam logic IN_BYTE = 1'b0;
  localparam logic IN_END  = 1'b1;

  typedef logic [NKW-1:0] kw_mask_t;

  function automatic logic [7:0] kw_char(input int k, input logic [3:0] i);
    string s;
    logic [7:0] c;
    case (k)
      0: s = "characterize";
      1: s = "reference";
      2: s = "power";
      3: s = "sweep";
      4: s = "frequency";
      5: s = "step";
      6: s = "measure";
      7: s = "derive";
      8: s = "calibration";
      9: s = "correction";
      10: s = "over";
      11: s = "Hz";
      12: s = "kHz";
      13: s = "MHz";
      14: s = "GHz";
      15: s = "dBm";
      default: s = "dB";
    endcase
    c = 8'd0;
    if (int'(i) < s.len()) c = s[int'(i)];
    return c;
  endfunction

  function automatic logic [3:0] kw_len(input int k);
    logic [3:0] l;
    case (k)
      0: l = 4'd12;
      1: l = 4'd9;
      2: l = 4'd5;
      3: l = 4'd5;
      4: l = 4'd9;
      5: l = 4'd4;
      6: l = 4'd7;
      7: l = 4'd6;
      8: l = 4'd11;
      9: l = 4'd10;
      10: l = 4'd4;
      11: l = 4'd2;
      12: l = 4'd3;
      13: l = 4'd3;
      14: l = 4'd3;
      15: l = 4'd3;
      default: l = 4'd2;
    endcase
    return l;
  endfunction

  function automatic logic [4:0] kw_kind(input int k);
    return (k < 11) ? 5'(k + 3) : 5'(k + 13);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_tail(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || c == "_";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      "=": k = K_EQUAL;
      "+": k = K_PLUS;
      "-": k = K_MINUS;
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      ",": k = K_COMMA;
      default: k = K_INVALID;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/bsl_in_if.sv =====
interface bsl_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] source_byte;
  modport source (output valid, kind, source_byte, input ready);
  modport sink (input valid, kind, source_byte, output ready);
endinterface

// ===== sv/bsl_out_if.sv =====
interface bsl_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [31:0] start_offset;
  logic [31:0] token_length;
  logic [23:0] start_line;
  logic [15:0] start_column;
  logic        last_in_run;
  modport source (output valid, token_kind, start_offset, token_length, start_line,
                  start_column, last_in_run, input ready);
  modport sink (input valid, token_kind, start_offset, token_length, start_line,
                start_column, last_in_run, output ready);
endinterface

// ===== sv/dsl_byte_stream_lexer.sv =====
// Byte stream lexer.
// in_ch: one request per source byte (kind 0) or end of source (kind 1).
// out_ch: tokens with kind, start offset, length, start line and column;
//   last_in_run marks the last token caused by one input request.
// A word, number, dot or invalid token is reported when the byte after it
// arrives (the lookahead); punctuation and range tokens are reported with
// their last byte. End of source flushes a pending token, reports end of
// file and returns the scan state to its reset values. Tokens reach out_ch
// through a registered two-entry result buffer. Throughput: one input per
// cycle while each input yields at most one token and the receiver takes
// every token; an input that yields two tokens fills the buffer and holds
// in_ready low until the first is taken. Input is taken while results wait,
// as long as the buffer has room for the two results an input may cause; a
// stalled receiver eventually holds in_ready low, with no loss.
// Reset (rst_n low, synchronous): mode idle, position offset 0, line 1,
// column 1, result buffer empty.
module dsl_byte_stream_lexer #(
  parameter int OFFSET_BITS = bsl_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = bsl_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = bsl_pkg::COLUMN_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  bsl_in_if.sink    in_ch,
  bsl_out_if.source out_ch
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

  typedef struct packed {
    logic [4:0]             kind;
    logic [OFFSET_BITS-1:0] boff;
    logic [OFFSET_BITS-1:0] len;
    logic [LINE_BITS-1:0]   bline;
    logic [COLUMN_BITS-1:0] bcol;
    logic                   last;
  } tok_t;

  bsl_pkg::mode_t         mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] cur_off_r, cur_off_nxt;
  logic [LINE_BITS-1:0]   cur_line_r, cur_line_nxt;
  logic [COLUMN_BITS-1:0] cur_col_r, cur_col_nxt;
  logic [OFFSET_BITS-1:0] beg_off_r, beg_off_nxt;
  logic [LINE_BITS-1:0]   beg_line_r, beg_line_nxt;
  logic [COLUMN_BITS-1:0] beg_col_r, beg_col_nxt;
  logic [OFFSET_BITS-1:0] dot_off_r, dot_off_nxt;
  logic [LINE_BITS-1:0]   dot_line_r, dot_line_nxt;
  logic [COLUMN_BITS-1:0] dot_col_r, dot_col_nxt;
  bsl_pkg::kw_mask_t      kw_r, kw_nxt;
  logic [3:0]             wlen_r, wlen_nxt;
  logic                   mal_r, mal_nxt;

  tok_t       buf_r [2];
  logic [1:0] cnt_r;
  logic       rd_r;

  logic                   acc, pop;
  logic [7:0]             c;
  logic [OFFSET_BITS-1:0] nxt_off;
  logic [1:0]             n;
  tok_t                   t0, t1;
  logic [4:0]             wkind;

  assign in_ch.ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ch.ready);
  assign acc = in_ch.valid && in_ch.ready;
  assign pop = out_ch.valid && out_ch.ready;
  assign c = in_ch.source_byte;
  assign nxt_off = (cur_off_r != OFF_MAX) ? cur_off_r + 1'b1 : cur_off_r;

  function automatic tok_t mk(input logic [4:0] k, input logic [OFFSET_BITS-1:0] bo,
                              input logic [LINE_BITS-1:0] bl,
                              input logic [COLUMN_BITS-1:0] bc,
                              input logic [OFFSET_BITS-1:0] eo);
    tok_t t;
    t.kind  = k;
    t.boff  = bo;
    t.len   = (eo >= bo) ? eo - bo : '0;
    t.bline = bl;
    t.bcol  = bc;
    t.last  = 1'b0;
    return t;
  endfunction

  always_comb begin
    wkind = bsl_pkg::K_IDENT;
    for (int k = bsl_pkg::NKW - 1; k >= 0; k--) begin
      if (kw_r[k] && bsl_pkg::kw_len(k) == wlen_r) wkind = bsl_pkg::kw_kind(k);
    end
  end

  always_comb begin
    logic flush, do_fresh;
    flush = 1'b0;
    do_fresh = 1'b0;
    mode_nxt = mode_r;
    cur_off_nxt = cur_off_r;
    cur_line_nxt = cur_line_r;
    cur_col_nxt = cur_col_r;
    beg_off_nxt = beg_off_r;
    beg_line_nxt = beg_line_r;
    beg_col_nxt = beg_col_r;
    dot_off_nxt = dot_off_r;
    dot_line_nxt = dot_line_r;
    dot_col_nxt = dot_col_r;
    kw_nxt = kw_r;
    wlen_nxt = wlen_r;
    mal_nxt = mal_r;
    n = 2'd0;
    t0 = mk(bsl_pkg::K_EOF, beg_off_r, beg_line_r, beg_col_r, cur_off_r);
    t1 = t0;

    if (in_ch.kind == bsl_pkg::IN_END) begin
      flush = 1'b1;
      case (mode_r)
        bsl_pkg::M_WORD: begin
          t0.kind = wkind; n = 2'd1;
        end
        bsl_pkg::M_INT, bsl_pkg::M_FRAC: begin
          t0.kind = mal_r ? bsl_pkg::K_INVALID : bsl_pkg::K_NUMBER; n = 2'd1;
        end
        bsl_pkg::M_DOT: begin
          t0.kind = bsl_pkg::K_DOT; n = 2'd1;
        end
        bsl_pkg::M_SLASH, bsl_pkg::M_INT_DOT, bsl_pkg::M_FRAC_DOT, bsl_pkg::M_TAIL,
        bsl_pkg::M_DOT_DIGITS: begin
          t0.kind = bsl_pkg::K_INVALID; n = 2'd1;
        end
        default: ;
      endcase
      if (n == 2'd1) begin
        t1 = mk(bsl_pkg::K_EOF, cur_off_r, cur_line_r, cur_col_r, cur_off_r);
        t1.last = 1'b1;
        n = 2'd2;
      end else begin
        t0 = mk(bsl_pkg::K_EOF, cur_off_r, cur_line_r, cur_col_r, cur_off_r);
        t0.last = 1'b1;
        n = 2'd1;
      end
    end else begin
      case (mode_r)
        bsl_pkg::M_COMMENT: if (c == 8'h0a) mode_nxt = bsl_pkg::M_IDLE;
        bsl_pkg::M_SLASH: begin
          if (c == "/") mode_nxt = bsl_pkg::M_COMMENT;
          else begin
            t0.kind = bsl_pkg::K_INVALID; n = 2'd1; do_fresh = 1'b1;
          end
        end
        bsl_pkg::M_WORD: begin
          if (bsl_pkg::is_tail(c)) begin
            for (int k = 0; k < bsl_pkg::NKW; k++) begin
              if (!(wlen_r < bsl_pkg::kw_len(k) && bsl_pkg::kw_char(k, wlen_r) == c))
                kw_nxt[k] = 1'b0;
            end
            if (wlen_r != 4'd15) wlen_nxt = wlen_r + 4'd1;
          end else begin
            t0.kind = wkind; n = 2'd1; do_fresh = 1'b1;
          end
        end
        bsl_pkg::M_INT, bsl_pkg::M_FRAC: begin
          if (bsl_pkg::is_digit(c)) begin
          end else if (c == ".") begin
            dot_off_nxt = cur_off_r;
            dot_line_nxt = cur_line_r;
            dot_col_nxt = cur_col_r;
            mode_nxt = (mode_r == bsl_pkg::M_INT) ? bsl_pkg::M_INT_DOT : bsl_pkg::M_FRAC_DOT;
          end else if (bsl_pkg::is_tail(c)) begin
            mal_nxt = 1'b1; mode_nxt = bsl_pkg::M_TAIL;
          end else begin
            t0.kind = mal_r ? bsl_pkg::K_INVALID : bsl_pkg::K_NUMBER;
            n = 2'd1; do_fresh = 1'b1;
          end
        end
        bsl_pkg::M_INT_DOT, bsl_pkg::M_FRAC_DOT: begin
          if (c == ".") begin
            t0 = mk(bsl_pkg::K_NUMBER, beg_off_r, beg_line_r, beg_col_r, dot_off_r);
            t1 = mk(bsl_pkg::K_RANGE, dot_off_r, dot_line_r, dot_col_r, nxt_off);
            n = 2'd2;
            mode_nxt = bsl_pkg::M_IDLE;
          end else if (bsl_pkg::is_digit(c) && mode_r == bsl_pkg::M_INT_DOT) begin
            mode_nxt = bsl_pkg::M_FRAC;
          end else if (bsl_pkg::is_tail(c)) begin
            mal_nxt = 1'b1; mode_nxt = bsl_pkg::M_TAIL;
          end else begin
            t0.kind = bsl_pkg::K_INVALID; n = 2'd1; do_fresh = 1'b1;
          end
        end
        bsl_pkg::M_TAIL: begin
          if (!(bsl_pkg::is_tail(c) || c == ".")) begin
            t0.kind = bsl_pkg::K_INVALID; n = 2'd1; do_fresh = 1'b1;
          end
        end
        bsl_pkg::M_DOT: begin
          if (c == ".") begin
            t0 = mk(bsl_pkg::K_RANGE, beg_off_r, beg_line_r, beg_col_r, nxt_off);
            n = 2'd1;
            mode_nxt = bsl_pkg::M_IDLE;
          end else if (bsl_pkg::is_digit(c)) begin
            mode_nxt = bsl_pkg::M_DOT_DIGITS;
          end else begin
            t0.kind = bsl_pkg::K_DOT; n = 2'd1; do_fresh = 1'b1;
          end
        end
        bsl_pkg::M_DOT_DIGITS: begin
          if (!bsl_pkg::is_digit(c)) begin
            t0.kind = bsl_pkg::K_INVALID; n = 2'd1; do_fresh = 1'b1;
          end
        end
        default: do_fresh = 1'b1;
      endcase

      if (do_fresh) begin
        mode_nxt = bsl_pkg::M_IDLE;
        if (!bsl_pkg::is_space(c)) begin
          beg_off_nxt = cur_off_r;
          beg_line_nxt = cur_line_r;
          beg_col_nxt = cur_col_r;
          if (c == "/") mode_nxt = bsl_pkg::M_SLASH;
          else if (bsl_pkg::is_letter(c)) begin
            mode_nxt = bsl_pkg::M_WORD;
            for (int k = 0; k < bsl_pkg::NKW; k++)
              kw_nxt[k] = (bsl_pkg::kw_char(k, 4'd0) == c);
            wlen_nxt = 4'd1;
          end else if (bsl_pkg::is_digit(c)) begin
            mode_nxt = bsl_pkg::M_INT;
            mal_nxt = 1'b0;
          end else if (c == ".") mode_nxt = bsl_pkg::M_DOT;
          else begin
            if (n == 2'd0) begin
              t0 = mk(bsl_pkg::punct_kind(c), cur_off_r, cur_line_r, cur_col_r, nxt_off);
              n = 2'd1;
            end else begin
              t1 = mk(bsl_pkg::punct_kind(c), cur_off_r, cur_line_r, cur_col_r, nxt_off);
              n = 2'd2;
            end
          end
        end
      end

      cur_off_nxt = nxt_off;
      if (c == 8'h0a) begin
        if (cur_line_r != LINE_MAX) cur_line_nxt = cur_line_r + 1'b1;
        cur_col_nxt = COLUMN_BITS'(1);
      end else if (cur_col_r != COL_MAX) begin
        cur_col_nxt = cur_col_r + 1'b1;
      end
      if (n == 2'd1) t0.last = 1'b1;
      if (n == 2'd2) t1.last = 1'b1;
    end

    if (flush) begin
      mode_nxt = bsl_pkg::M_IDLE;
      cur_off_nxt = '0;
      cur_line_nxt = LINE_BITS'(1);
      cur_col_nxt = COLUMN_BITS'(1);
      beg_off_nxt = '0;
      beg_line_nxt = LINE_BITS'(1);
      beg_col_nxt = COLUMN_BITS'(1);
      dot_off_nxt = '0;
      dot_line_nxt = LINE_BITS'(1);
      dot_col_nxt = COLUMN_BITS'(1);
      kw_nxt = '0;
      wlen_nxt = 4'd0;
      mal_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bsl_pkg::M_IDLE;
      cur_off_r <= '0;
      cur_line_r <= LINE_BITS'(1);
      cur_col_r <= COLUMN_BITS'(1);
      beg_off_r <= '0;
      beg_line_r <= LINE_BITS'(1);
      beg_col_r <= COLUMN_BITS'(1);
      dot_off_r <= '0;
      dot_line_r <= LINE_BITS'(1);
      dot_col_r <= COLUMN_BITS'(1);
      kw_r <= '0;
      wlen_r <= 4'd0;
      mal_r <= 1'b0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      cur_off_r <= cur_off_nxt;
      cur_line_r <= cur_line_nxt;
      cur_col_r <= cur_col_nxt;
      beg_off_r <= beg_off_nxt;
      beg_line_r <= beg_line_nxt;
      beg_col_r <= beg_col_nxt;
      dot_off_r <= dot_off_nxt;
      dot_line_r <= dot_line_nxt;
      dot_col_r <= dot_col_nxt;
      kw_r <= kw_nxt;
      wlen_r <= wlen_nxt;
      mal_r <= mal_nxt;
    end
  end

  // two-entry result FIFO, read pointer rd_r
  always_ff @(posedge clk) begin
    logic [1:0] cnt_v;
    logic       wp;
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
    end else begin
      cnt_v = cnt_r - {1'b0, pop};
      wp = rd_r ^ pop ^ cnt_v[0];
      if (acc && n != 2'd0) begin
        buf_r[wp] <= t0;
        if (n == 2'd2) buf_r[~wp] <= t1;
      end
      cnt_r <= cnt_v + (acc ? n : 2'd0);
      if (pop) rd_r <= ~rd_r;
    end
  end

  tok_t head;
  assign head = buf_r[rd_r];
  assign out_ch.valid = (cnt_r != 2'd0);
  assign out_ch.token_kind = head.kind;
  assign out_ch.start_offset = 32'(head.boff);
  assign out_ch.token_length = 32'(head.len);
  assign out_ch.start_line = 24'(head.bline);
  assign out_ch.start_column = 16'(head.bcol);
  assign out_ch.last_in_run = head.last;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("result count overflow");
  a_no_acc_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !in_ch.ready)
    else $error("input taken with full buffer");
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_ch.kind == bsl_pkg::IN_END |=> mode_r == bsl_pkg::M_IDLE && cur_off_r == '0)
    else $error("end of source did not reset state");
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(mode_r))
    else $error("mode not one-hot");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [31:0] start_offset;
    logic [31:0] token_length;
    logic [23:0] start_line;
    logic [15:0] start_column;
    logic        last_in_run;
  } token_t;

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk;
  logic rst_n;

  bsl_in_if  in_ch ();
  bsl_out_if out_ch ();

  dsl_byte_stream_lexer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // predictor state
  bsl_pkg::mode_t    lx_mode;
  logic [31:0]       lx_off;
  logic [23:0]       lx_line;
  logic [15:0]       lx_col;
  logic [31:0]       tok_off;
  logic [23:0]       tok_line;
  logic [15:0]       tok_col;
  logic [31:0]       dot_off;
  logic [23:0]       dot_line;
  logic [15:0]       dot_col;
  bsl_pkg::kw_mask_t kw_live;
  logic [3:0]        word_len;
  logic              bad_num;

  token_t token_q[$];
  token_t run_toks[$];
  int     fail_count;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic lexer_reset();
    lx_mode = bsl_pkg::M_IDLE;
    lx_off = '0;
    lx_line = 24'd1;
    lx_col = 16'd1;
    tok_off = '0;
    tok_line = 24'd1;
    tok_col = 16'd1;
    dot_off = '0;
    dot_line = 24'd1;
    dot_col = 16'd1;
    kw_live = '0;
    word_len = '0;
    bad_num = 1'b0;
  endtask

  function automatic logic [31:0] off_plus1();
    return (lx_off == '1) ? lx_off : lx_off + 32'd1;
  endfunction

  task automatic push_tok(input logic [4:0] k, input logic [31:0] bo, input logic [23:0] bl,
                          input logic [15:0] bc, input logic [31:0] eo);
    token_t t;
    t.token_kind = k;
    t.start_offset = bo;
    t.token_length = (eo >= bo) ? eo - bo : '0;
    t.start_line = bl;
    t.start_column = bc;
    t.last_in_run = 1'b0;
    run_toks = {run_toks, t};
  endtask

  task automatic push_begun(input logic [4:0] k, input logic [31:0] eo);
    push_tok(k, tok_off, tok_line, tok_col, eo);
  endtask

  task automatic word_extend(input logic [7:0] c);
    for (int k = 0; k < bsl_pkg::NKW; k++)
      if (!(word_len < bsl_pkg::kw_len(k) && bsl_pkg::kw_char(k, word_len) == c))
        kw_live[k] = 1'b0;
    if (word_len < 4'd15) word_len++;
  endtask

  function automatic logic [4:0] word_class();
    for (int k = 0; k < bsl_pkg::NKW; k++)
      if (kw_live[k] && bsl_pkg::kw_len(k) == word_len) return bsl_pkg::kw_kind(k);
    return bsl_pkg::K_IDENT;
  endfunction

  task automatic start_token(input logic [7:0] c);
    lx_mode = bsl_pkg::M_IDLE;
    if (!bsl_pkg::is_space(c)) begin
      tok_off = lx_off;
      tok_line = lx_line;
      tok_col = lx_col;
      if (c == "/") lx_mode = bsl_pkg::M_SLASH;
      else if (bsl_pkg::is_letter(c)) begin
        lx_mode = bsl_pkg::M_WORD;
        kw_live = '1;
        word_len = '0;
        word_extend(c);
      end else if (bsl_pkg::is_digit(c)) begin
        lx_mode = bsl_pkg::M_INT;
        bad_num = 1'b0;
      end else if (c == ".") lx_mode = bsl_pkg::M_DOT;
      else push_begun(bsl_pkg::punct_kind(c), off_plus1());
    end
  endtask

  task automatic close_then_start(input logic [4:0] k, input logic [7:0] c);
    push_begun(k, lx_off);
    start_token(c);
  endtask

  task automatic predict_tokens(input logic kind, input logic [7:0] c);
    run_toks.delete();
    if (kind == bsl_pkg::IN_END) begin
      case (lx_mode)
        bsl_pkg::M_WORD: push_begun(word_class(), lx_off);
        bsl_pkg::M_INT, bsl_pkg::M_FRAC:
          push_begun(bad_num ? bsl_pkg::K_INVALID : bsl_pkg::K_NUMBER, lx_off);
        bsl_pkg::M_DOT: push_begun(bsl_pkg::K_DOT, lx_off);
        bsl_pkg::M_SLASH, bsl_pkg::M_INT_DOT, bsl_pkg::M_FRAC_DOT, bsl_pkg::M_TAIL,
        bsl_pkg::M_DOT_DIGITS: push_begun(bsl_pkg::K_INVALID, lx_off);
        default: ;
      endcase
      push_tok(bsl_pkg::K_EOF, lx_off, lx_line, lx_col, lx_off);
      lexer_reset();
    end else begin
      case (lx_mode)
        bsl_pkg::M_COMMENT: if (c == 8'h0a) lx_mode = bsl_pkg::M_IDLE;
        bsl_pkg::M_SLASH: begin
          if (c == "/") lx_mode = bsl_pkg::M_COMMENT;
          else close_then_start(bsl_pkg::K_INVALID, c);
        end
        bsl_pkg::M_WORD: begin
          if (bsl_pkg::is_tail(c)) word_extend(c);
          else close_then_start(word_class(), c);
        end
        bsl_pkg::M_INT, bsl_pkg::M_FRAC: begin
          if (bsl_pkg::is_digit(c)) ;
          else if (c == ".") begin
            dot_off = lx_off;
            dot_line = lx_line;
            dot_col = lx_col;
            lx_mode = (lx_mode == bsl_pkg::M_INT) ? bsl_pkg::M_INT_DOT : bsl_pkg::M_FRAC_DOT;
          end else if (bsl_pkg::is_tail(c)) begin
            bad_num = 1'b1;
            lx_mode = bsl_pkg::M_TAIL;
          end else close_then_start(bad_num ? bsl_pkg::K_INVALID : bsl_pkg::K_NUMBER, c);
        end
        bsl_pkg::M_INT_DOT, bsl_pkg::M_FRAC_DOT: begin
          if (c == ".") begin
            push_begun(bsl_pkg::K_NUMBER, dot_off);
            push_tok(bsl_pkg::K_RANGE, dot_off, dot_line, dot_col, off_plus1());
            lx_mode = bsl_pkg::M_IDLE;
          end else if (bsl_pkg::is_digit(c) && lx_mode == bsl_pkg::M_INT_DOT)
            lx_mode = bsl_pkg::M_FRAC;
          else if (bsl_pkg::is_tail(c)) begin
            bad_num = 1'b1;
            lx_mode = bsl_pkg::M_TAIL;
          end else close_then_start(bsl_pkg::K_INVALID, c);
        end
        bsl_pkg::M_TAIL:
          if (!(bsl_pkg::is_tail(c) || c == ".")) close_then_start(bsl_pkg::K_INVALID, c);
        bsl_pkg::M_DOT: begin
          if (c == ".") begin
            push_begun(bsl_pkg::K_RANGE, off_plus1());
            lx_mode = bsl_pkg::M_IDLE;
          end else if (bsl_pkg::is_digit(c)) lx_mode = bsl_pkg::M_DOT_DIGITS;
          else close_then_start(bsl_pkg::K_DOT, c);
        end
        bsl_pkg::M_DOT_DIGITS:
          if (!bsl_pkg::is_digit(c)) close_then_start(bsl_pkg::K_INVALID, c);
        default: start_token(c);
      endcase
      if (lx_off != '1) lx_off++;
      if (c == 8'h0a) begin
        if (lx_line != '1) lx_line++;
        lx_col = 16'd1;
      end else if (lx_col != '1) lx_col++;
    end
    if (run_toks.size() > 0) run_toks[run_toks.size()-1].last_in_run = 1'b1;
    token_q = {token_q, run_toks};
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic send_request(input logic kind, input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.source_byte <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_tokens(kind, c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(bsl_pkg::IN_BYTE, s[i]);
  endtask

  task automatic wait_drained();
    while (token_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    token_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (token_q.size() == 0) begin
        report_mismatch("unexpected token kind", 32'(out_ch.token_kind), 32'd0);
      end else begin
        w = token_q.pop_front();
        if (out_ch.token_kind !== w.token_kind)
          report_mismatch("kind", 32'(out_ch.token_kind), 32'(w.token_kind));
        if (out_ch.start_offset !== w.start_offset)
          report_mismatch("offset", out_ch.start_offset, w.start_offset);
        if (out_ch.token_length !== w.token_length)
          report_mismatch("length", out_ch.token_length, w.token_length);
        if (out_ch.start_line !== w.start_line)
          report_mismatch("line", 32'(out_ch.start_line), 32'(w.start_line));
        if (out_ch.start_column !== w.start_column)
          report_mismatch("column", 32'(out_ch.start_column), 32'(w.start_column));
        if (out_ch.last_in_run !== w.last_in_run)
          report_mismatch("last", 32'(out_ch.last_in_run), 32'(w.last_in_run));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_keywords();
    send_text("characterize reference power sweep frequency step measure derive ");
    send_text("calibration correction over Hz kHz MHz GHz dBm dB dBmx Hzz z_9 ");
    send_request(bsl_pkg::IN_END, 8'h00);
  endtask

  task automatic test_numbers();
    send_text("0 12.5 7.3.1 9x 4.x 1..2 3. 3.4..5 5.6_a ..7 .8a .q ");
    send_request(bsl_pkg::IN_END, 8'h00);
    send_text("42.");
    send_request(bsl_pkg::IN_END, 8'h00);
  endtask

  task automatic test_punct_comments();
    send_text("{}=+-(),/a //note\n\t\v\f\r");
    send_request(bsl_pkg::IN_BYTE, 8'h00);
    send_request(bsl_pkg::IN_BYTE, 8'hff);
    send_request(bsl_pkg::IN_BYTE, 8'h80);
    send_text("#/");
    send_request(bsl_pkg::IN_END, 8'h00);
    send_text(".");
    send_request(bsl_pkg::IN_END, 8'h55);
    send_request(bsl_pkg::IN_END, 8'h00);
  endtask

  function automatic logic [7:0] pick_byte();
    string pool;
    case ($urandom_range(9))
      0, 1: pool = "abcdefghiklmnopqrstuvwyzHMGBz_";
      2, 3: pool = "0123456789";
      4: pool = "..";
      5: pool = " \n\t";
      6: pool = "{}=+-(),/";
      7: return 8'($urandom_range(255));
      default: begin
        pool = "characterizecalibrationGHzdBm";
      end
    endcase
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  task automatic test_random(input int count);
    string words[8] = '{"characterize", "calibration", "GHz", "dBm", "dB", "12.5",
                        "1..9", "//x\n"};
    int sent;
    int w;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(3) == 0) begin
        w = $urandom_range(7);
        send_text(words[w]);
        sent += words[w].len();
      end else begin
        send_request(bsl_pkg::IN_BYTE, pick_byte());
        sent++;
      end
      if ($urandom_range(60) == 0) begin
        send_request(bsl_pkg::IN_END, 8'($urandom_range(255)));
        sent++;
      end
    end
    send_request(bsl_pkg::IN_END, 8'h00);
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    lexer_reset();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= bsl_pkg::IN_BYTE;
    in_ch.source_byte <= 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_keywords();
    test_numbers();
    test_punct_comments();
    send_idle_pct = 21;
    recv_idle_pct = 77;
    test_random(500);
    send_idle_pct = 77;
    recv_idle_pct = 21;
    test_random(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(500);
    in_ch.valid <= 1'b0;
    wait_drained();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
